FILE: hw/rtl/rca_pkg.sv
// Shared types and constants for the resource claim allocator.
// Used by rca_decide and resource_claim_allocator; no dependencies.
`default_nettype none

package rca_pkg;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DUP     = 3'd1,
      ST_FULL    = 3'd2,
      ST_CLAIM   = 3'd3,
      ST_UNKNOWN = 3'd4,
      ST_REFUSED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   localparam logic [1:0] CSR_TOTAL_A = 2'd0;
   localparam logic [1:0] CSR_TOTAL_B = 2'd1;
   localparam logic [1:0] CSR_TOTAL_C = 2'd2;

   localparam logic [7:0] RESET_TOTAL_A = 8'd10;
   localparam logic [7:0] RESET_TOTAL_B = 8'd5;
   localparam logic [7:0] RESET_TOTAL_C = 8'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] task_id;
      logic [7:0] amount_a;
      logic [7:0] amount_b;
      logic [7:0] amount_c;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] fail_mask;
      logic [7:0] avail_a;
      logic [7:0] avail_b;
      logic [7:0] avail_c;
   } rsp_type;

   // One row of the task table.
   typedef struct packed {
      logic [7:0] task_id;
      logic [7:0] claim_a;
      logic [7:0] claim_b;
      logic [7:0] claim_c;
      logic [7:0] held_a;
      logic [7:0] held_b;
      logic [7:0] held_c;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic [2:0] fail_mask;
      logic       do_add;
      logic       do_alloc;
      logic       do_release;
   } decision_type;

   function automatic logic [7:0] sat_sub(input logic [7:0] x, input logic [7:0] y);
      sat_sub = (x > y) ? (x - y) : 8'd0;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rca_decide.sv
// Admission and grant checks for one operation of the resource claim allocator.
// Depends on rca_pkg for the item, table row and decision types.
`default_nettype none

module rca_decide
   import rca_pkg::*;
(
   input  wire req_type      req,
   input  wire logic [7:0]   avail_a,
   input  wire logic [7:0]   avail_b,
   input  wire logic [7:0]   avail_c,
   input  wire logic         match_found,
   input  wire entry_type    match_entry,
   input  wire logic         free_found,
   output decision_type      dec
);

   logic [2:0] avail_mask;
   logic [2:0] need_mask;

   always_comb begin
      avail_mask[0] = req.amount_a > avail_a;
      avail_mask[1] = req.amount_b > avail_b;
      avail_mask[2] = req.amount_c > avail_c;
      need_mask[0]  = req.amount_a > sat_sub(match_entry.claim_a, match_entry.held_a);
      need_mask[1]  = req.amount_b > sat_sub(match_entry.claim_b, match_entry.held_b);
      need_mask[2]  = req.amount_c > sat_sub(match_entry.claim_c, match_entry.held_c);
   end

   always_comb begin
      dec = '0;
      dec.status = ST_OK;
      unique case (op_type'(req.operation))
         OP_ADD: begin
            if (match_found) begin
               dec.status = ST_DUP;
            end else if (avail_mask != 3'd0) begin
               dec.status    = ST_CLAIM;
               dec.fail_mask = avail_mask;
            end else if (!free_found) begin
               dec.status = ST_FULL;
            end else begin
               dec.do_add = 1'b1;
            end
         end
         OP_ALLOC: begin
            if (!match_found) begin
               dec.status = ST_UNKNOWN;
            end else if ((avail_mask | need_mask) != 3'd0) begin
               dec.status    = ST_REFUSED;
               dec.fail_mask = avail_mask | need_mask;
            end else begin
               dec.do_alloc = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (!match_found) begin
               dec.status = ST_UNKNOWN;
            end else begin
               dec.do_release = 1'b1;
            end
         end
         default: begin
            dec.status = ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/resource_claim_allocator.sv
// Resource claim allocator: each accepted item goes through a scan, which reads one table row
// a cycle through the single read port and waits for the registered read to drain, then an
// update. One item is in flight at a time and the block returns to idle before the next accept.
// A stalled result holds the update. Reset restores totals to 10, 5, 7, clears usage and marks
// every slot free; the table rows themselves are not cleared.
`default_nettype none

module resource_claim_allocator
   import rca_pkg::*;
#(
   parameter int TASK_SLOTS = 16
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   // Task table.
   entry_type table_mem [TASK_SLOTS];
   entry_type rd_data_ff;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   req_type          req_ff;
   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   entry_type        match_entry_ff, match_entry_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [7:0]       total_a_ff, total_b_ff, total_c_ff;
   logic [7:0]       used_a_ff, used_b_ff, used_c_ff;
   logic [7:0]       used_a_in, used_b_in, used_c_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             rd_en;
   logic             exec_fire;
   logic             cnt_done;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_entry;
   decision_type     dec;

   assign cnt_done = (cnt_ff == CNT_W'(TASK_SLOTS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SCAN;
         S_SCAN: if (cnt_done && !rd_vld_ff) state_in = S_EXEC;
         S_EXEC: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      exec_fire = 1'b0;
      unique case (state_ff)
         S_IDLE: req_stall = 1'b0;
         S_SCAN: rd_en = !cnt_done;
         S_EXEC: exec_fire = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Scan bookkeeping: keep the lowest matching valid slot and the lowest free slot.
   always_comb begin
      cnt_in         = cnt_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_entry_in = match_entry_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      if (accept) begin
         cnt_in         = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end else begin
         if (rd_en) cnt_in = cnt_ff + CNT_W'(1);
         if (rd_vld_ff) begin
            if (valid_ff[rd_idx_ff] && rd_data_ff.task_id == req_ff.task_id
                && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = rd_idx_ff;
               match_entry_in = rd_data_ff;
            end
            if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
         end
      end
   end

   rca_decide u_decide (
      .req         (req_ff),
      .avail_a     (sat_sub(total_a_ff, used_a_ff)),
      .avail_b     (sat_sub(total_b_ff, used_b_ff)),
      .avail_c     (sat_sub(total_c_ff, used_c_ff)),
      .match_found (match_found_ff),
      .match_entry (match_entry_ff),
      .free_found  (free_found_ff),
      .dec         (dec)
   );

   // Update of the table row, the valid bits and the pool.
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = match_idx_ff;
      wr_entry  = match_entry_ff;
      valid_in  = valid_ff;
      used_a_in = used_a_ff;
      used_b_in = used_b_ff;
      used_c_in = used_c_ff;
      if (exec_fire) begin
         if (dec.do_add) begin
            wr_en            = 1'b1;
            wr_idx           = free_idx_ff;
            wr_entry.task_id = req_ff.task_id;
            wr_entry.claim_a = req_ff.amount_a;
            wr_entry.claim_b = req_ff.amount_b;
            wr_entry.claim_c = req_ff.amount_c;
            wr_entry.held_a  = 8'd0;
            wr_entry.held_b  = 8'd0;
            wr_entry.held_c  = 8'd0;
            valid_in[free_idx_ff] = 1'b1;
         end
         if (dec.do_alloc) begin
            wr_en           = 1'b1;
            wr_entry.held_a = match_entry_ff.held_a + req_ff.amount_a;
            wr_entry.held_b = match_entry_ff.held_b + req_ff.amount_b;
            wr_entry.held_c = match_entry_ff.held_c + req_ff.amount_c;
            used_a_in       = used_a_ff + req_ff.amount_a;
            used_b_in       = used_b_ff + req_ff.amount_b;
            used_c_in       = used_c_ff + req_ff.amount_c;
         end
         if (dec.do_release) begin
            used_a_in = sat_sub(used_a_ff, match_entry_ff.held_a);
            used_b_in = sat_sub(used_b_ff, match_entry_ff.held_b);
            used_c_in = sat_sub(used_c_ff, match_entry_ff.held_c);
            valid_in[match_idx_ff] = 1'b0;
         end
      end
   end

   // Result register: hold until taken, load on update.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (exec_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = dec.status;
         rsp_data_in.fail_mask = dec.fail_mask;
         rsp_data_in.avail_a   = sat_sub(total_a_ff, used_a_in);
         rsp_data_in.avail_b   = sat_sub(total_b_ff, used_b_in);
         rsp_data_in.avail_c   = sat_sub(total_c_ff, used_c_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= table_mem[cnt_ff[IDX_W-1:0]];
      if (wr_en) table_mem[wr_idx] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         used_a_ff    <= 8'd0;
         used_b_ff    <= 8'd0;
         used_c_ff    <= 8'd0;
         total_a_ff   <= RESET_TOTAL_A;
         total_b_ff   <= RESET_TOTAL_B;
         total_c_ff   <= RESET_TOTAL_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         valid_ff     <= valid_in;
         used_a_ff    <= used_a_in;
         used_b_ff    <= used_b_in;
         used_c_ff    <= used_c_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TOTAL_A: total_a_ff <= csr_wdata;
               CSR_TOTAL_B: total_b_ff <= csr_wdata;
               CSR_TOTAL_C: total_c_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= cnt_ff[IDX_W-1:0];
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_entry_ff <= match_entry_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      rsp_data_ff    <= rsp_data_in;
      if (accept) req_ff <= req_data;
   end

endmodule

`default_nettype wire
